// ===== rtl/tct_pkg.sv =====
// ----------------------------------------------------------------------------
// tct_pkg - shared types and constants of the text console teletype
// Screen geometry, field widths, item kinds, sequencer states and the
// request and response words of the two channels.
// ----------------------------------------------------------------------------
package tct_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;

	localparam int KIND_W   = 3;
	localparam int CHAR_W   = 8;
	localparam int ATTR_W   = 8;
	localparam int COL_W    = 7;
	localparam int ROW_W    = 5;
	localparam int CELL_W   = CHAR_W + ATTR_W;
	localparam int ADDR_W   = $clog2(CELLS);
	localparam int PTR_W    = $clog2(CELLS + 1);

	localparam logic [KIND_W-1:0] KIND_TELETYPE = 3'd0;
	localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_SET_CUR  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_PUT      = 3'd3;
	localparam logic [KIND_W-1:0] KIND_READ     = 3'd4;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
	localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
	localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h00;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SCROLL,
		ST_FILL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CHAR_W-1:0] char_code;
		logic [ATTR_W-1:0] attribute;
		logic [COL_W-1:0]  column;
		logic [ROW_W-1:0]  row;
	} req_t;

	typedef struct packed {
		logic [COL_W-1:0]  cursor_column;
		logic [ROW_W-1:0]  cursor_row_shown;
		logic [CHAR_W-1:0] cell_char;
		logic [ATTR_W-1:0] cell_attribute;
	} rsp_t;

	// write and read port controls of the screen store
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [CELL_W-1:0] data;
	} cell_wr_t;

	typedef struct packed {
		logic              re;
		logic [ADDR_W-1:0] addr;
	} cell_rd_t;

	// row * COLUMNS + column; constant multiply reduces to shifts and adds
	function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] r,
			logic [COL_W-1:0] c);
		logic [ADDR_W-1:0] a;
		a = ADDR_W'(ADDR_W'(r) * ADDR_W'(COLUMNS)) + ADDR_W'(c);
		return a;
	endfunction

endpackage

// ===== rtl/text_console_teletype_core.sv =====
// ----------------------------------------------------------------------------
// text_console_teletype_core - 80x25 character-cell screen engine
// Request words carry a kind (teletype, clear, set cursor, put, read) plus
// character, attribute and cell position. Every request gives exactly one
// response word with the cursor after the request and, for a read, the cell.
// Both channels are valid/ready; the response sits in an output register,
// so the next request is taken as soon as that register is free or drained.
// Teletype without scroll, set cursor, put, unknown kinds and out-of-range
// reads answer in the cycle after acceptance; an in-range read passes the
// store's read register and ST_DONE before its response is loaded. Clear
// walks all CELLS (2000) cells one cell a cycle. A teletype that leaves the
// bottom row scrolls: a pipelined copy moves rows 1 to ROWS-1 one row up
// (one read and one write per cycle on the store), then the bottom row's
// COLUMNS cells are filled with spaces; req_ready is low meanwhile. Simple
// kinds are taken one request a cycle while rsp_ready stays high. Reset
// puts the cursor home and shows it; store contents stay undefined until
// written. A stalled response holds; the engine then waits with req_ready
// low until the response is taken. cfg_we/cfg_wdata write cursor_visible;
// the user does so only while the engine is idle, unenforced by the block.
// ----------------------------------------------------------------------------
module text_console_teletype_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	input  logic          req_valid,
	output logic          req_ready,
	input  tct_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output tct_pkg::rsp_t rsp
);
	import tct_pkg::*;

	state_t             state_q, state_d;
	logic [COL_W-1:0]   cur_col_q, cur_col_d;
	logic [ROW_W-1:0]   cur_row_q, cur_row_d;
	logic [PTR_W-1:0]   ptr_q, ptr_d;
	logic [ATTR_W-1:0]  attr_q, attr_d;
	logic               rd_hit_q, rd_hit_d;
	logic               visible_q;
	logic               pend_s1, pend_d;
	logic [ADDR_W-1:0]  paddr_s1, paddr_d;
	logic               rsp_valid_q;
	rsp_t               rsp_q, rsp_d;
	logic               rsp_load;
	logic               out_free;
	logic               accept;
	logic               in_range;
	logic               done_now;
	cell_wr_t           wr;
	cell_rd_t           rd;
	logic [CELL_W-1:0]  rd_data;

	tct_screen_ram u_ram (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE) && out_free;
	assign accept    = req_valid && req_ready;
	assign in_range  = (int'(req.column) < COLUMNS) && (int'(req.row) < ROWS);

	always_comb begin
		state_d   = state_q;
		cur_col_d = cur_col_q;
		cur_row_d = cur_row_q;
		ptr_d     = ptr_q;
		attr_d    = attr_q;
		rd_hit_d  = rd_hit_q;
		pend_d    = 1'b0;
		paddr_d   = paddr_s1;
		done_now  = 1'b0;
		rsp_load  = 1'b0;
		wr.we     = 1'b0;
		wr.addr   = cell_addr(req.row, req.column);
		wr.data   = {req.attribute, req.char_code};
		rd.re     = 1'b0;
		rd.addr   = cell_addr(req.row, req.column);

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					rd_hit_d = 1'b0;
					case (req.kind)
						KIND_TELETYPE: begin
							attr_d = req.attribute;
							if (req.char_code != NEWLINE_CODE) begin
								wr.we   = 1'b1;
								wr.addr = cell_addr(cur_row_q, cur_col_q);
							end
							if (req.char_code == NEWLINE_CODE
									|| int'(cur_col_q) == COLUMNS - 1) begin
								cur_col_d = '0;
								if (int'(cur_row_q) == ROWS - 1) begin
									ptr_d   = PTR_W'(COLUMNS);
									state_d = ST_SCROLL;
								end else begin
									cur_row_d = cur_row_q + 1'b1;
									done_now  = 1'b1;
								end
							end else begin
								cur_col_d = cur_col_q + 1'b1;
								done_now  = 1'b1;
							end
						end
						KIND_CLEAR: begin
							attr_d    = req.attribute;
							cur_col_d = '0;
							cur_row_d = '0;
							ptr_d     = '0;
							state_d   = ST_CLEAR;
						end
						KIND_SET_CUR: begin
							cur_col_d = (int'(req.column) >= COLUMNS) ?
								COL_W'(COLUMNS - 1) : req.column;
							cur_row_d = (int'(req.row) >= ROWS) ?
								ROW_W'(ROWS - 1) : req.row;
							done_now  = 1'b1;
						end
						KIND_PUT: begin
							wr.we    = in_range;
							done_now = 1'b1;
						end
						KIND_READ: begin
							if (in_range) begin
								rd.re    = 1'b1;
								rd_hit_d = 1'b1;
								state_d  = ST_DONE;
							end else begin
								done_now = 1'b1;
							end
						end
						default: begin
							done_now = 1'b1;
						end
					endcase
				end
			end
			ST_CLEAR: begin
				wr.we   = 1'b1;
				wr.addr = ptr_q[ADDR_W-1:0];
				wr.data = {attr_q, BLANK_CODE};
				if (int'(ptr_q) == CELLS - 1) begin
					state_d = ST_DONE;
				end else begin
					ptr_d = ptr_q + 1'b1;
				end
			end
			ST_SCROLL: begin
				// read one row down, write it back in the next cycle one row up
				wr.we   = pend_s1;
				wr.addr = paddr_s1;
				wr.data = rd_data;
				if (int'(ptr_q) != CELLS) begin
					rd.re   = 1'b1;
					rd.addr = ptr_q[ADDR_W-1:0];
					pend_d  = 1'b1;
					paddr_d = ptr_q[ADDR_W-1:0] - ADDR_W'(COLUMNS);
					ptr_d   = ptr_q + 1'b1;
				end else begin
					ptr_d   = PTR_W'(CELLS - COLUMNS);
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				wr.we   = 1'b1;
				wr.addr = ptr_q[ADDR_W-1:0];
				wr.data = {attr_q, SPACE_CODE};
				if (int'(ptr_q) == CELLS - 1) begin
					state_d = ST_DONE;
				end else begin
					ptr_d = ptr_q + 1'b1;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (done_now) begin
			rsp_load = 1'b1;
		end

		rsp_d.cursor_column    = cur_col_d;
		rsp_d.cursor_row_shown = visible_q ? cur_row_d : ROW_W'(ROWS);
		rsp_d.cell_char        = (rd_hit_q && !done_now) ? rd_data[CHAR_W-1:0] : '0;
		rsp_d.cell_attribute   = (rd_hit_q && !done_now) ? rd_data[CELL_W-1:CHAR_W] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			ptr_q       <= '0;
			rd_hit_q    <= 1'b0;
			visible_q   <= 1'b1;
			pend_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cur_col_q <= cur_col_d;
			cur_row_q <= cur_row_d;
			ptr_q     <= ptr_d;
			rd_hit_q  <= rd_hit_d;
			pend_s1   <= pend_d;
			if (cfg_we) begin
				visible_q <= cfg_wdata;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		attr_q   <= attr_d;
		paddr_s1 <= paddr_d;
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// busy sequencer must never take a new word
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !req_ready)
		else $error("request taken while sequencer busy");

	a_cursor_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(cur_col_q) < COLUMNS) && (int'(cur_row_q) < ROWS))
		else $error("cursor off screen");

	a_copy_in_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (state_q == ST_SCROLL))
		else $error("scroll copy pending outside scroll");

	a_scroll_keeps_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCROLL) |-> (int'(cur_row_q) == ROWS - 1))
		else $error("scroll with cursor off bottom row");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |-> out_free)
		else $error("response register overwritten");

endmodule

// ===== rtl/tct_screen_ram.sv =====
// ----------------------------------------------------------------------------
// tct_screen_ram - character/attribute store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tct_screen_ram (
	input  logic                    clk,
	input  tct_pkg::cell_wr_t       wr,
	input  tct_pkg::cell_rd_t       rd,
	output logic [tct_pkg::CELL_W-1:0] rd_data
);
	import tct_pkg::*;

	logic [CELL_W-1:0] mem_q [CELLS];
	logic [CELL_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd.re) begin
			rd_data_q <= mem_q[rd.addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
